[rtl/core/cfcb_pkg.sv]
// Shared types, step codes and the byte-wise CRC-16 update for the frame builder.
package cfcb_pkg;

  localparam logic [15:0] CRC_INIT  = 16'hC181;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] BYTE_MASK = 16'h00FF;

  localparam logic [7:0] CFG_DEST_ID = 8'd0;
  localparam logic [7:0] CFG_COMMAND = 8'd1;

  localparam logic [2:0] ST_HDR0 = 3'd0;
  localparam logic [2:0] ST_HDR1 = 3'd1;
  localparam logic [2:0] ST_CMD  = 3'd2;
  localparam logic [2:0] ST_DATA = 3'd3;
  localparam logic [2:0] ST_CRCL = 3'd4;
  localparam logic [2:0] ST_CRCH = 3'd5;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       frame_end;
  } beat_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ ({8'h00, b} & BYTE_MASK);
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/cfcb_seq.sv]
// Work register and byte sequencer: emits header, payload and CRC beats of one item.
module cfcb_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  input  logic                  start_hdr_i,
  input  logic [15:0]           dest_id_i,
  input  logic [7:0]            command_i,
  input  logic                  out_free_i,
  output cfcb_pkg::beat_t       beat_o,
  output logic                  ready_o
);
  import cfcb_pkg::*;

  logic        work_valid_q, work_valid_d;
  logic [2:0]  step_q, step_d, step_nxt;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [15:0] crc_q, crc_nxt;
  logic [7:0]  emit_data;
  logic        emit_end;
  logic        done;
  logic        adv;
  logic        finish;

  assign adv    = work_valid_q && out_free_i;
  assign finish = adv && done;
  assign ready_o = !work_valid_q || finish;

  always_comb begin
    emit_data = byte_q;
    emit_end  = 1'b0;
    crc_nxt   = crc_q;
    step_nxt  = step_q;
    done      = 1'b1;
    unique case (step_q)
      ST_HDR0: begin
        emit_data = dest_id_i[7:0];
        crc_nxt   = crc_feed(CRC_INIT, dest_id_i[7:0]);
        step_nxt  = ST_HDR1;
        done      = 1'b0;
      end
      ST_HDR1: begin
        emit_data = dest_id_i[15:8];
        crc_nxt   = crc_feed(crc_q, dest_id_i[15:8]);
        step_nxt  = ST_CMD;
        done      = 1'b0;
      end
      ST_CMD: begin
        emit_data = command_i;
        crc_nxt   = crc_feed(crc_q, command_i);
        step_nxt  = ST_DATA;
        done      = 1'b0;
      end
      ST_DATA: begin
        emit_data = byte_q;
        crc_nxt   = crc_feed(crc_q, byte_q);
        step_nxt  = ST_CRCL;
        done      = !last_q;
      end
      ST_CRCL: begin
        emit_data = crc_q[7:0];
        step_nxt  = ST_CRCH;
        done      = 1'b0;
      end
      ST_CRCH: begin
        emit_data = crc_q[15:8];
        emit_end  = 1'b1;
        crc_nxt   = CRC_INIT;
        done      = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_comb begin
    work_valid_d = work_valid_q;
    step_d       = step_q;
    if (load_i) begin
      work_valid_d = 1'b1;
      step_d       = start_hdr_i ? ST_HDR0 : ST_DATA;
    end else if (finish) begin
      work_valid_d = 1'b0;
    end else if (adv) begin
      step_d = step_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      step_q       <= ST_HDR0;
    end else begin
      work_valid_q <= work_valid_d;
      step_q       <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      byte_q <= byte_i;
      last_q <= last_i;
    end
    if (adv) begin
      crc_q <= crc_nxt;
    end
  end

  assign beat_o.valid     = adv;
  assign beat_o.data      = emit_data;
  assign beat_o.frame_end = emit_end;

  a_crcl_then_crch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && step_q == ST_CRCL |=> work_valid_q && step_q == ST_CRCH)
    else $error("CRC low beat not followed by CRC high beat");

  a_crc_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_valid_q && (step_q == ST_CRCL || step_q == ST_CRCH) |-> last_q)
    else $error("CRC beat on an item without last flag");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_valid_q && !adv |=> work_valid_q && $stable(step_q))
    else $error("sequencer moved while output stalled");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !work_valid_q || finish)
    else $error("item loaded over unfinished work");

endmodule

[rtl/core/cfcb_out.sv]
// Output register: holds one frame beat until the receiver takes it.
module cfcb_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfcb_pkg::beat_t beat_i,
  input  logic            out_ready_i,
  output logic            free_o,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            frame_end_o
);
  import cfcb_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       end_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = beat_i.valid ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i.valid) begin
      data_q <= beat_i.data;
      end_q  <= beat_i.frame_end;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = data_q;
  assign frame_end_o = end_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i.valid |-> free_o)
    else $error("beat written over a waiting beat");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q && $stable(data_q) && $stable(end_q))
    else $error("waiting beat changed");

  a_frame_end_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && end_q && !out_ready_i |=> end_q)
    else $error("frame end flag lost");

endmodule

[rtl/core/command_frame_crc16_builder_top.sv]
// Top level of the command frame builder with reflected CRC-16.
//
// Input channel: one payload byte per beat with a last flag (in_valid_i/in_ready_o).
// The first byte of a frame is preceded by dest_id low, dest_id high and the
// command byte; the last byte is followed by CRC low and CRC high, the latter
// flagged by frame_end_o. CRC-16 reflected, poly 0xA001, init 0xC181.
// Output channel: one frame byte per beat (out_valid_o/out_ready_i).
// Configuration: cfg_valid_i/cfg_ready_o write dest_id (index 0) or
// command_code (index 1); write only while idle. Other indexes are ignored.
// An accepted item is held in the sequencer's work register; its beats reach the receiver through the output register.
// Throughput: one output beat per cycle from the output register while the receiver
// takes every beat; an item yields 1 beat mid-frame, 4 when it opens a frame, 3 when
// it closes one and 6 for a one-byte frame, issued from the sequencer's work register.
// Reset: empties the pipeline, no frame open, registers read zero.
// Receiver stall: the output beat holds, the sequencer holds, and in_ready_o
// drops once the work register is occupied.
module command_frame_crc16_builder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  payload_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import cfcb_pkg::*;

  logic [15:0] dest_id_q;
  logic [7:0]  command_q;
  logic        frame_open_q;
  logic        in_accept;
  logic        out_free;
  beat_t       beat;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_id_q    <= 16'h0000;
      command_q    <= 8'h00;
      frame_open_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == CFG_DEST_ID) begin
        dest_id_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == CFG_COMMAND) begin
        command_q <= cfg_data_i[7:0];
      end
      if (in_accept) begin
        frame_open_q <= !last_byte_i;
      end
    end
  end

  cfcb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_accept),
    .byte_i      (payload_byte_i),
    .last_i      (last_byte_i),
    .start_hdr_i (!frame_open_q),
    .dest_id_i   (dest_id_q),
    .command_i   (command_q),
    .out_free_i  (out_free),
    .beat_o      (beat),
    .ready_o     (in_ready_o)
  );

  cfcb_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .out_ready_i (out_ready_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o)
  );

endmodule

[tb/sv/tb.sv]
// Self-checking bench for the command frame builder: predicts header, payload and CRC beats.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfcb_pkg::*;

  localparam logic [7:0] CFG_NONE = 8'hFF;
  localparam int IDLE_PCT = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } wire_beat_t;

  class frame_model;
    logic [15:0] dest_id;
    logic [7:0]  cmd;
    logic [15:0] crc;
    bit          open;
    wire_beat_t  wire_q[$];
    int          errors;

    function new();
      dest_id = '0;
      cmd     = '0;
      crc     = CRC_INIT;
      open    = 1'b0;
      errors  = 0;
    endfunction

    function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
      c = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function void write_reg(logic [7:0] idx, logic [15:0] data);
      if (idx == CFG_DEST_ID) begin
        dest_id = data;
      end else if (idx == CFG_COMMAND) begin
        cmd = data[7:0];
      end
    endfunction

    function void push_wire(logic [7:0] b, logic fin, bit feed);
      wire_beat_t w;
      w.data = b;
      w.fin  = fin;
      wire_q.push_back(w);
      if (feed) begin
        crc = crc_byte(crc, b);
      end
    endfunction

    function void take_payload(logic [7:0] b, logic last);
      logic [15:0] sum;
      if (!open) begin
        crc = CRC_INIT;
        push_wire(dest_id[7:0], 1'b0, 1'b1);
        push_wire(dest_id[15:8], 1'b0, 1'b1);
        push_wire(cmd, 1'b0, 1'b1);
        open = 1'b1;
      end
      push_wire(b, 1'b0, 1'b1);
      if (last) begin
        sum = crc;
        push_wire(sum[7:0], 1'b0, 1'b0);
        push_wire(sum[15:8], 1'b1, 1'b0);
        crc  = CRC_INIT;
        open = 1'b0;
      end
    endfunction

    function void check_wire_byte(logic [7:0] data, logic fin);
      wire_beat_t want;
      if (wire_q.size() == 0) begin
        $display("%0t: unexpected beat out_byte=%02h frame_end=%0b", $time, data, fin);
        errors++;
        return;
      end
      want = wire_q.pop_front();
      if (want.data !== data) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
        errors++;
      end
      if (want.fin !== fin) begin
        $display("%0t: frame_end expected %0b actual %0b", $time, want.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [7:0]  payload_byte_i = '0;
  logic        last_byte_i    = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [7:0]  out_byte_o;
  logic        frame_end_o;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i    = '0;
  logic [15:0] cfg_data_i     = '0;

  bit          steady         = 1'b0;
  frame_model  model;

  command_frame_crc16_builder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .payload_byte_i (payload_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .frame_end_o    (frame_end_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      model.check_wire_byte(out_byte_o, frame_end_o);
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    payload_byte_i <= b;
    last_byte_i    <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    model.take_payload(b, last);
    @(negedge clk_i);
  endtask

  task automatic send_frame(int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom), i == len - 1);
    end
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    model.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (model.wire_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic shuffle_regs();
    logic [15:0] d;
    logic [7:0]  c;
    case ($urandom_range(0, 3))
      0:       d = 16'h0000;
      1:       d = 16'hFFFF;
      default: d = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       c = 8'h00;
      1:       c = 8'hFF;
      default: c = 8'($urandom);
    endcase
    write_reg(CFG_DEST_ID, d);
    write_reg(CFG_COMMAND, {8'($urandom), c});
    if ($urandom_range(0, 1) == 0) begin
      write_reg(8'($urandom_range(2, 255)), 16'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int count;
    int len;
    model = new();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset register values, one-byte frame
    send_byte(8'h00, 1'b1);
    drain();

    write_reg(CFG_DEST_ID, 16'hFFFF);
    write_reg(CFG_COMMAND, 16'hFFFF);
    cfg_valid_i <= 1'b0;
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();

    write_reg(CFG_DEST_ID, 16'hA5C3);
    write_reg(CFG_COMMAND, 16'h0000);
    cfg_valid_i <= 1'b0;
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);

    // write registers with a frame open: new header only on the next frame
    send_byte(8'h7F, 1'b0);
    drain();
    write_reg(CFG_DEST_ID, 16'h1234);
    write_reg(CFG_COMMAND, 16'h003C);
    write_reg(CFG_NONE, 16'hFFFF);
    cfg_valid_i <= 1'b0;
    send_byte(8'hAA, 1'b1);
    send_byte(8'hFE, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'h3C, 1'b1);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      steady = (phase == 2);
      shuffle_regs();
      count = 0;
      while (count < 32) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
        send_frame(len);
        count += len;
      end
      drain();
    end
    steady = 1'b0;

    repeat (10) @(posedge clk_i);
    if (model.errors == 0 && model.wire_q.size() == 0) begin
      $display("command_frame_crc16_builder_top: match");
    end else begin
      $display("command_frame_crc16_builder_top: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("command_frame_crc16_builder_top: mismatch");
    $finish;
  end

endmodule

[files.f]
rtl/core/cfcb_pkg.sv
rtl/core/cfcb_seq.sv
rtl/core/cfcb_out.sv
rtl/core/command_frame_crc16_builder_top.sv
tb/sv/tb.sv
